// ===== design/swfr_pkg.sv =====
package swfr_pkg;

  // Payload geometry
  localparam int unsigned FRAME_BYTES = 15;
  localparam int unsigned DATA_W      = 8 * FRAME_BYTES;
  localparam int unsigned LO_W        = 64;
  localparam int unsigned HI_W        = DATA_W - LO_W;

  // Item modes
  typedef enum logic [1:0] {
    MODE_FRAME = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_SEND  = 2'd2
  } mode_e;

  // Result actions
  typedef enum logic [2:0] {
    ACT_ACK    = 3'd0,
    ACT_NACK   = 3'd1,
    ACT_RESEND = 3'd2,
    ACT_DONE   = 3'd3,
    ACT_ERROR  = 3'd4
  } action_e;

  // Fixed frame type codes
  localparam logic [3:0] TYPE_NACK  = 4'd9;
  localparam logic [3:0] TYPE_END   = 4'd13;
  localparam logic [3:0] TYPE_ERROR = 4'd15;

  // Register indexes
  localparam logic [1:0] CFG_MARKER  = 2'd0;
  localparam logic [1:0] CFG_DTYPE   = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;
  localparam logic [1:0] CFG_LATE    = 2'd3;

  // Register reset values
  localparam logic [7:0]  MARKER_RST  = 8'd126;
  localparam logic [3:0]  DTYPE_RST   = 4'd12;
  localparam logic [15:0] TIMEOUT_RST = 16'd12;

  typedef struct packed {
    logic [1:0]      mode;
    logic [7:0]      marker;
    logic [3:0]      frame_size;
    logic [7:0]      frame_seq;
    logic [3:0]      frame_type;
    logic [7:0]      frame_parity;
    logic [LO_W-1:0] data_lo;
    logic [HI_W-1:0] data_hi;
  } in_item_t;

  typedef struct packed {
    action_e         action;
    logic [LO_W-1:0] payload_lo;
    logic [HI_W-1:0] payload_hi;
    logic [3:0]      payload_len;
    logic [7:0]      err_code;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  marker_value;
    logic [3:0]  data_type;
    logic [15:0] timeout_ticks;
    logic        late_retry;
  } cfg_t;

  // Frame check results handed to the controller
  typedef struct packed {
    logic            marker_ok;
    logic            parity_ok;
    logic [LO_W-1:0] payload_lo;
    logic [HI_W-1:0] payload_hi;
    logic [3:0]      payload_len;
    logic [7:0]      err_code;
  } chk_t;

endpackage

// ===== design/stop_wait_frame_receiver.sv =====
// Stop-and-wait receiver: takes command-sent, timer-tick and received-frame
// items, checks frames (marker, XOR parity over size/seq/type/data, expected
// sequence) and gives at most one result per item: ACK with the payload,
// NACK, resend request, end-of-transfer ACK or server error code. Throughput
// is one item per clock while the consumer does not stall: an item waits in
// the input register while the frame check and the transfer state update run,
// then its result lands in the output register. in_stall_o rises only while
// the output register holds a result that the consumer is stalling; items
// without a result still wait their turn there. Configuration writes are
// always ready and take effect on the next cycle; write them only while no
// item is in flight.
module stop_wait_frame_receiver
  import swfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t      cfg_q, cfg_d;
  logic      in_valid_q, in_valid_d;
  in_item_t  in_item_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;
  logic      out_free;
  logic      advance;
  chk_t      chk;
  logic      res_valid;
  out_item_t res;
  logic      active;

  // Output register can take a new result this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  // Register file
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MARKER:  cfg_d.marker_value  = cfg_data_i[7:0];
        CFG_DTYPE:   cfg_d.data_type     = cfg_data_i[3:0];
        CFG_TIMEOUT: cfg_d.timeout_ticks = cfg_data_i;
        CFG_LATE:    cfg_d.late_retry    = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.marker_value  <= MARKER_RST;
      cfg_q.data_type     <= DTYPE_RST;
      cfg_q.timeout_ticks <= TIMEOUT_RST;
      cfg_q.late_retry    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input register
  assign in_valid_d = in_stall_o ? in_valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  swfr_check u_check (
    .item_i (in_item_q),
    .cfg_i  (cfg_q),
    .chk_o  (chk)
  );

  swfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .item_i      (in_item_q),
    .chk_i       (chk),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .active_o    (active)
  );

  // Output register
  assign out_valid_d = out_free ? (advance && res_valid) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef NO_ASSERTIONS
  // Back-pressure comes only from a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // Only ACK results carry payload
  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.action != ACT_ACK) |->
      (out_item_o.payload_lo == '0 && out_item_o.payload_hi == '0 &&
       out_item_o.payload_len == '0))
    else $error("payload on non-ACK result");

  // A transfer closes only with an end ACK or a server error
  a_close_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(active) |->
      (out_valid_o && (out_item_o.action == ACT_DONE ||
                       out_item_o.action == ACT_ERROR)))
    else $error("transfer closed without done or error result");
`endif

endmodule

// ===== design/swfr_check.sv =====
module swfr_check
  import swfr_pkg::*;
(
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output chk_t     chk_o
);

  logic [DATA_W-1:0] data;
  logic [DATA_W-1:0] kept;
  logic [3:0]        size_c;
  logic [7:0]        par;

  assign data = {item_i.data_hi, item_i.data_lo};

  always_comb begin
    if (32'(item_i.frame_size) > FRAME_BYTES) begin
      size_c = 4'(FRAME_BYTES);
    end else begin
      size_c = item_i.frame_size;
    end
    par  = {4'd0, size_c} ^ item_i.frame_seq ^ {4'd0, item_i.frame_type};
    kept = '0;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (5'(i) < {1'b0, size_c}) begin
        par             = par ^ data[8*i +: 8];
        kept[8*i +: 8]  = data[8*i +: 8];
      end
    end
  end

  assign chk_o.marker_ok   = (item_i.marker == cfg_i.marker_value);
  assign chk_o.parity_ok   = (par == item_i.frame_parity);
  assign chk_o.payload_lo  = kept[LO_W-1:0];
  assign chk_o.payload_hi  = kept[DATA_W-1:LO_W];
  assign chk_o.payload_len = size_c;
  assign chk_o.err_code    = data[7:0];

endmodule

// ===== design/swfr_ctrl.sv =====
module swfr_ctrl
  import swfr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      advance_i,
  input  in_item_t  item_i,
  input  chk_t      chk_i,
  input  cfg_t      cfg_i,
  output logic      res_valid_o,
  output out_item_t res_o,
  output logic      active_o
);

  logic [7:0]  expected_seq_q, expected_seq_d;
  logic        active_q, active_d;
  logic        data_seen_q, data_seen_d;
  logic [15:0] wait_timer_q, wait_timer_d;
  logic [15:0] timer_inc;
  logic        retry_ok;
  logic        good;

  assign retry_ok  = cfg_i.late_retry || !data_seen_q;
  assign good      = chk_i.parity_ok && (item_i.frame_seq == expected_seq_q);
  assign timer_inc = (wait_timer_q == '1) ? wait_timer_q : wait_timer_q + 16'd1;

  always_comb begin
    expected_seq_d = expected_seq_q;
    active_d       = active_q;
    data_seen_d    = data_seen_q;
    wait_timer_d   = wait_timer_q;
    res_valid_o    = 1'b0;
    res_o          = '0;
    res_o.action   = ACT_ACK;

    case (item_i.mode)
      MODE_SEND: begin
        if (!active_q) begin
          active_d       = 1'b1;
          expected_seq_d = 8'd1;
          data_seen_d    = 1'b0;
        end
        wait_timer_d = '0;
      end
      MODE_TICK: begin
        if (active_q && retry_ok) begin
          if (timer_inc > cfg_i.timeout_ticks) begin
            wait_timer_d = '0;
            res_valid_o  = 1'b1;
            res_o.action = ACT_RESEND;
          end else begin
            wait_timer_d = timer_inc;
          end
        end
      end
      MODE_FRAME: begin
        if (active_q && chk_i.marker_ok) begin
          if (item_i.frame_type == cfg_i.data_type) begin
            res_valid_o = 1'b1;
            if (good) begin
              res_o.action      = ACT_ACK;
              res_o.payload_lo  = chk_i.payload_lo;
              res_o.payload_hi  = chk_i.payload_hi;
              res_o.payload_len = chk_i.payload_len;
              expected_seq_d    = expected_seq_q + 8'd1;
              data_seen_d       = 1'b1;
            end else begin
              res_o.action = ACT_NACK;
            end
          end else if (item_i.frame_type == TYPE_END) begin
            res_valid_o = 1'b1;
            if (good) begin
              res_o.action = ACT_DONE;
              active_d     = 1'b0;
            end else begin
              res_o.action = ACT_NACK;
            end
          end else if (item_i.frame_type == TYPE_NACK) begin
            if (retry_ok) begin
              wait_timer_d = '0;
              res_valid_o  = 1'b1;
              res_o.action = ACT_RESEND;
            end
          end else if (item_i.frame_type == TYPE_ERROR) begin
            active_d       = 1'b0;
            res_valid_o    = 1'b1;
            res_o.action   = ACT_ERROR;
            res_o.err_code = chk_i.err_code;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_seq_q <= '0;
      active_q       <= 1'b0;
      data_seen_q    <= 1'b0;
      wait_timer_q   <= '0;
    end else if (advance_i) begin
      expected_seq_q <= expected_seq_d;
      active_q       <= active_d;
      data_seen_q    <= data_seen_d;
      wait_timer_q   <= wait_timer_d;
    end
  end

  assign active_o = active_q;

endmodule
